// File: rtl/i2c_clock_divider_search_core_macros.svh
// assertion helpers shared by the rtl
`ifndef I2C_CLOCK_DIVIDER_SEARCH_CORE_MACROS_SVH
`define I2C_CLOCK_DIVIDER_SEARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ICDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ICDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ICDS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ICDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/icds_pkg.sv
`default_nettype none

package icds_pkg;

    localparam int DATA_W       = 32;
    localparam int MANTISSA_MAX = 15;
    localparam int EXPONENT_MAX = 7;
    localparam int RATE_SCALE   = 10;

    localparam int MANTISSA_W = $clog2(MANTISSA_MAX + 1);
    localparam int EXPONENT_W = $clog2(EXPONENT_MAX + 1);
    localparam int WORD_W     = MANTISSA_W + EXPONENT_W;
    localparam int DIVISOR_W  =
        $clog2(RATE_SCALE * (MANTISSA_MAX + 1) * (2 ** EXPONENT_MAX) + 1);
    localparam int COUNT_W    = $clog2(DATA_W);

    localparam logic [MANTISSA_W-1:0] MANTISSA_LAST    = MANTISSA_W'(MANTISSA_MAX);
    localparam logic [EXPONENT_W-1:0] EXPONENT_LAST    = EXPONENT_W'(EXPONENT_MAX);
    localparam logic [MANTISSA_W-1:0] DEFAULT_MANTISSA = MANTISSA_W'(5);
    localparam logic [EXPONENT_W-1:0] DEFAULT_EXPONENT = EXPONENT_W'(0);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // 10 * (m + 1) * 2^n
    function automatic logic [DIVISOR_W-1:0] pair_divisor(
        input logic [MANTISSA_W-1:0] m,
        input logic [EXPONENT_W-1:0] n
    );
        logic [DIVISOR_W-1:0] base;
        base = (DIVISOR_W'(m) + DIVISOR_W'(1)) * DIVISOR_W'(RATE_SCALE);
        return base << n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/icds_in_if.sv
`default_nettype none

interface icds_in_if;
    logic                         valid;
    logic                         ready;
    logic [icds_pkg::DATA_W-1:0]  input_clock_hz;
    logic [icds_pkg::DATA_W-1:0]  wanted_rate_hz;

    modport source (output valid, output input_clock_hz, output wanted_rate_hz, input ready);
    modport sink   (input valid, input input_clock_hz, input wanted_rate_hz, output ready);
endinterface

`default_nettype wire

// File: rtl/icds_out_if.sv
`default_nettype none

interface icds_out_if;
    logic                             valid;
    logic                             ready;
    logic [icds_pkg::MANTISSA_W-1:0]  mantissa;
    logic [icds_pkg::EXPONENT_W-1:0]  exponent;
    logic [icds_pkg::WORD_W-1:0]      divider_word;
    logic                             fit_found;

    modport source (output valid, output mantissa, output exponent, output divider_word,
                    output fit_found, input ready);
    modport sink   (input valid, input mantissa, input exponent, input divider_word,
                    input fit_found, output ready);
endinterface

`default_nettype wire

// File: rtl/icds_divider.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module icds_divider (
    input  wire                              clk,
    input  wire                              rst_n,
    input  icds_pkg::div_ctrl_t              ctrl,
    output icds_pkg::div_stat_t              stat,
    input  wire [icds_pkg::DATA_W-1:0]       dividend,
    input  wire [icds_pkg::DIVISOR_W-1:0]    divisor,
    output logic [icds_pkg::DATA_W-1:0]      quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [icds_pkg::COUNT_W-1:0]      count_reg;
    logic [icds_pkg::DATA_W-1:0]       quo_reg;
    logic [icds_pkg::DIVISOR_W-1:0]    rem_reg;
    logic [icds_pkg::DIVISOR_W-1:0]    divisor_reg;

    logic [icds_pkg::DIVISOR_W:0]      shifted;
    logic [icds_pkg::DIVISOR_W:0]      diff;
    logic                              fits;
    logic [icds_pkg::DATA_W-1:0]       quo_next;
    logic [icds_pkg::DIVISOR_W-1:0]    rem_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[icds_pkg::DATA_W-1]};
        diff     = shifted - {1'b0, divisor_reg};
        fits     = (shifted >= {1'b0, divisor_reg});
        quo_next = {quo_reg[icds_pkg::DATA_W-2:0], fits};
        rem_next = fits ? diff[icds_pkg::DIVISOR_W-1:0] : shifted[icds_pkg::DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + icds_pkg::COUNT_W'(1);
                if (count_reg == icds_pkg::COUNT_W'(icds_pkg::DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// File: rtl/i2c_clock_divider_search_core.sv
// channel   dir  payload                                         transaction
// request   in   input_clock_hz[31:0], wanted_rate_hz[31:0]      one search
// result    out  mantissa[3:0], exponent[2:0],                   one answer
//                divider_word[6:0], fit_found
//
// every (m, n) pair runs the same steps: a start that loads the shared serial divider,
// 32 quotient bits, the done pulse, and a check that compares and steps.
// a search covers 128 pairs before the result is offered. request is not ready
// from acceptance on, and stays low while the result waits on a stalled sink.
// no clearing pass after reset.
`default_nettype none
`include "i2c_clock_divider_search_core_macros.svh"

module i2c_clock_divider_search_core (
    input  wire         clk,
    input  wire         rst_n,
    icds_in_if.sink     request,
    icds_out_if.source  result
);

    icds_pkg::state_t                    state_reg;
    icds_pkg::state_t                    state_next;

    logic [icds_pkg::DATA_W-1:0]         clock_reg;
    logic [icds_pkg::DATA_W-1:0]         wanted_reg;
    logic [icds_pkg::MANTISSA_W-1:0]     m_reg;
    logic [icds_pkg::EXPONENT_W-1:0]     n_reg;
    logic [icds_pkg::MANTISSA_W-1:0]     sel_m_reg;
    logic [icds_pkg::EXPONENT_W-1:0]     sel_n_reg;
    logic [icds_pkg::DATA_W-1:0]         best_freq_reg;
    logic                                have_fit_reg;

    icds_pkg::div_ctrl_t                 div_ctrl;
    icds_pkg::div_stat_t                 div_stat;
    logic [icds_pkg::DATA_W-1:0]         freq;

    logic                                last_pair;
    logic                                better;
    logic                                accept;

    icds_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .stat     (div_stat),
        .dividend (clock_reg),
        .divisor  (icds_pkg::pair_divisor(m_reg, n_reg)),
        .quotient (freq)
    );

    assign accept    = request.valid && request.ready;
    assign last_pair = (m_reg == icds_pkg::MANTISSA_LAST) && (n_reg == icds_pkg::EXPONENT_LAST);
    // a larger freq that still fits means a smaller gap; ties keep the earlier pair
    assign better    = (freq <= wanted_reg) && (!have_fit_reg || (freq > best_freq_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            icds_pkg::ST_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = icds_pkg::ST_START;
                end
            end
            icds_pkg::ST_START:
            begin
                state_next = icds_pkg::ST_WAIT;
            end
            icds_pkg::ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = icds_pkg::ST_CHECK;
                end
            end
            icds_pkg::ST_CHECK:
            begin
                state_next = last_pair ? icds_pkg::ST_DONE : icds_pkg::ST_START;
            end
            icds_pkg::ST_DONE:
            begin
                if (result.ready)
                begin
                    state_next = icds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = icds_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        request.ready  = 1'b0;
        result.valid   = 1'b0;
        div_ctrl.start = 1'b0;
        unique case (state_reg)
            icds_pkg::ST_IDLE:  request.ready  = 1'b1;
            icds_pkg::ST_START: div_ctrl.start = 1'b1;
            icds_pkg::ST_DONE:  result.valid   = 1'b1;
            default:
            begin
                request.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= icds_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_fit_reg <= 1'b0;
            sel_m_reg    <= icds_pkg::DEFAULT_MANTISSA;
            sel_n_reg    <= icds_pkg::DEFAULT_EXPONENT;
        end
        else if (accept)
        begin
            have_fit_reg <= 1'b0;
            sel_m_reg    <= icds_pkg::DEFAULT_MANTISSA;
            sel_n_reg    <= icds_pkg::DEFAULT_EXPONENT;
        end
        else if ((state_reg == icds_pkg::ST_CHECK) && better)
        begin
            have_fit_reg <= 1'b1;
            sel_m_reg    <= m_reg;
            sel_n_reg    <= n_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clock_reg  <= request.input_clock_hz;
            wanted_reg <= request.wanted_rate_hz;
            m_reg      <= '0;
            n_reg      <= '0;
        end
        else if (state_reg == icds_pkg::ST_CHECK)
        begin
            if (better)
            begin
                best_freq_reg <= freq;
            end
            if (m_reg == icds_pkg::MANTISSA_LAST)
            begin
                m_reg <= '0;
                n_reg <= n_reg + icds_pkg::EXPONENT_W'(1);
            end
            else
            begin
                m_reg <= m_reg + icds_pkg::MANTISSA_W'(1);
            end
        end
    end

    assign result.mantissa     = sel_m_reg;
    assign result.exponent     = sel_n_reg;
    assign result.divider_word = {sel_m_reg, sel_n_reg};
    assign result.fit_found    = have_fit_reg;

    `ICDS_ASSERT_IMPL(a_no_overlap, clk, rst_n, result.valid, !request.ready)
    `ICDS_ASSERT_IMPL(a_start_idle_div, clk, rst_n, div_ctrl.start, !div_stat.busy)
    `ICDS_ASSERT_IMPL(a_default_pair, clk, rst_n, !have_fit_reg,
        (sel_m_reg == icds_pkg::DEFAULT_MANTISSA) && (sel_n_reg == icds_pkg::DEFAULT_EXPONENT))
    `ICDS_ASSERT_IMPL(a_best_fits, clk, rst_n, have_fit_reg && (state_reg == icds_pkg::ST_DONE),
        best_freq_reg <= wanted_reg)
    `ICDS_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == icds_pkg::ST_START)

endmodule

`default_nettype wire

// File: bench/tb_i2c_clock_divider_search_core.sv
`timescale 1ns / 1ps

module tb_i2c_clock_divider_search_core;
    import icds_pkg::*;

    localparam int SLOWEST_DIVISOR  = RATE_SCALE * (MANTISSA_MAX + 1) * (2 ** EXPONENT_MAX);
    localparam int SINK_HOLD_CYCLES = 10000;
    localparam int WATCHDOG_LIMIT   = 40000;
    localparam int TAIL_CYCLES      = 5000;
    localparam int PHASE_ITEMS      = 24;

    typedef struct packed {
        logic [DATA_W-1:0] clock_hz;
        logic [DATA_W-1:0] wanted_hz;
    } rate_request_t;

    typedef struct packed {
        logic [MANTISSA_W-1:0] mantissa;
        logic [EXPONENT_W-1:0] exponent;
        logic [WORD_W-1:0]     divider_word;
        logic                  fit_found;
    } divider_choice_t;

    logic clk = 1'b0;
    logic rst_n;

    icds_in_if  request_bus ();
    icds_out_if result_bus ();

    i2c_clock_divider_search_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_bus),
        .result  (result_bus)
    );

    rate_request_t   pending_requests[$];
    divider_choice_t expected_choices[$];
    rate_request_t   staged_request;
    divider_choice_t oldest_choice;

    int sender_idle_pct;
    int sink_stall_pct;
    int hold_left;
    logic hold_trigger;
    int quiet_cycles;
    int error_count;
    int searches_accepted;
    int results_checked;
    int unfit_results;

    always #5 clk = ~clk;

    // walks every (m, n) pair in search order, keeps the closest rate not above wanted
    function automatic divider_choice_t search_divider(input logic [DATA_W-1:0] clock_hz,
                                                       input logic [DATA_W-1:0] wanted_hz);
        divider_choice_t pick;
        logic [63:0]     divisor;
        logic [63:0]     rate;
        logic [63:0]     gap;
        logic [63:0]     best_gap;
        pick.mantissa  = DEFAULT_MANTISSA;
        pick.exponent  = DEFAULT_EXPONENT;
        pick.fit_found = 1'b0;
        best_gap       = '0;
        for (int n = 0; n <= EXPONENT_MAX; n++)
        begin
            for (int m = 0; m <= MANTISSA_MAX; m++)
            begin
                divisor = 64'(RATE_SCALE * (m + 1)) << n;
                rate    = {32'b0, clock_hz} / divisor;
                if (rate <= {32'b0, wanted_hz})
                begin
                    gap = {32'b0, wanted_hz} - rate;
                    if (!pick.fit_found || gap < best_gap)
                    begin
                        pick.fit_found = 1'b1;
                        best_gap       = gap;
                        pick.mantissa  = MANTISSA_W'(m);
                        pick.exponent  = EXPONENT_W'(n);
                    end
                end
            end
        end
        pick.divider_word = {pick.mantissa, pick.exponent};
        return pick;
    endfunction

    function automatic logic [DATA_W-1:0] corner_value();
        case ($urandom_range(3))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic rate_request_t random_request();
        rate_request_t r;
        int            m;
        int            n;
        case ($urandom_range(9))
            0, 1, 2, 3, 4:
            begin
                // typical peripheral clocks and bus rates
                r.clock_hz  = $urandom_range(600_000_000, 1_000_000);
                r.wanted_hz = $urandom_range(3_400_000, 10_000);
            end
            5:
            begin
                // wanted rate hit exactly by some pair
                m           = $urandom_range(MANTISSA_MAX);
                n           = $urandom_range(EXPONENT_MAX);
                r.clock_hz  = $urandom;
                r.wanted_hz = r.clock_hz / (32'(RATE_SCALE * (m + 1)) << n);
            end
            6:
            begin
                // below the slowest pair, nothing fits
                r.clock_hz  = $urandom_range(32'hffff_ffff, 2 * SLOWEST_DIVISOR);
                r.wanted_hz = $urandom_range(r.clock_hz / SLOWEST_DIVISOR - 1, 0);
            end
            7, 8:
            begin
                r.clock_hz  = $urandom;
                r.wanted_hz = $urandom;
            end
            default:
            begin
                r.clock_hz  = corner_value();
                r.wanted_hz = corner_value();
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_request(input logic [DATA_W-1:0] clock_hz,
                                 input logic [DATA_W-1:0] wanted_hz);
        rate_request_t r;
        r.clock_hz  = clock_hz;
        r.wanted_hz = wanted_hz;
        pending_requests.push_back(r);
    endtask

    task automatic queue_random(input int count);
        repeat (count) pending_requests.push_back(random_request());
    endtask

    // sender holds back until every search has been answered
    task automatic drain_all();
        while (pending_requests.size() != 0 || request_bus.valid
               || expected_choices.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int sender_pct, input int sink_pct);
        sender_idle_pct = sender_pct;
        sink_stall_pct  = sink_pct;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_bus.valid          <= 1'b0;
            request_bus.input_clock_hz <= '0;
            request_bus.wanted_rate_hz <= '0;
        end
        else
        begin
            if (request_bus.valid && request_bus.ready)
            begin
                expected_choices.push_back(search_divider(request_bus.input_clock_hz,
                                                          request_bus.wanted_rate_hz));
                searches_accepted++;
            end
            if (!request_bus.valid || request_bus.ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    staged_request              = pending_requests.pop_front();
                    request_bus.valid          <= 1'b1;
                    request_bus.input_clock_hz <= staged_request.clock_hz;
                    request_bus.wanted_rate_hz <= staged_request.wanted_hz;
                end
                else
                    request_bus.valid <= 1'b0;
            end
        end
    end

    // long sink hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_trigger)
            hold_left <= SINK_HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_choices.size() == 0)
                    report_mismatch($sformatf("result with no search pending, word %0d",
                                              result_bus.divider_word));
                else
                begin
                    oldest_choice = expected_choices.pop_front();
                    results_checked++;
                    if (!oldest_choice.fit_found)
                        unfit_results++;
                    if (result_bus.mantissa !== oldest_choice.mantissa)
                        report_mismatch($sformatf("mantissa got %0d expected %0d",
                                                  result_bus.mantissa, oldest_choice.mantissa));
                    if (result_bus.exponent !== oldest_choice.exponent)
                        report_mismatch($sformatf("exponent got %0d expected %0d",
                                                  result_bus.exponent, oldest_choice.exponent));
                    if (result_bus.divider_word !== oldest_choice.divider_word)
                        report_mismatch($sformatf("divider_word got %0d expected %0d",
                                                  result_bus.divider_word,
                                                  oldest_choice.divider_word));
                    if (result_bus.fit_found !== oldest_choice.fit_found)
                        report_mismatch($sformatf("fit_found got %0d expected %0d",
                                                  result_bus.fit_found,
                                                  oldest_choice.fit_found));
                end
            end
            result_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (request_bus.valid && request_bus.ready)
            || (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n                      = 1'b0;
        hold_trigger               = 1'b0;
        error_count                = 0;
        searches_accepted          = 0;
        results_checked            = 0;
        unfit_results              = 0;
        set_idling(0, 0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        queue_request(32'd0, 32'd0);
        queue_request(32'd0, 32'hffff_ffff);
        queue_request(32'hffff_ffff, 32'd0);
        queue_request(32'hffff_ffff, 32'hffff_ffff);
        queue_request(32'd1, 32'd0);
        queue_request(32'd10, 32'd1);
        queue_request(32'd25, 32'd1);
        queue_request(32'd5, 32'd3);
        queue_request(32'hffff_ffff, 32'd1000);
        queue_request(32'd100_000_000, 32'd4882);
        queue_request(32'd100_000_000, 32'd4881);
        queue_request(32'd100_000_000, 32'd1_250_000);
        queue_request(32'd100_000_000, 32'd100_000);
        queue_request(32'd100_000_000, 32'd400_000);
        queue_request(32'd24_000_000, 32'd100_000);
        queue_request(32'd24_000_000, 32'd400_000);
        queue_request(32'd600_000_000, 32'd3_400_000);
        queue_request(32'hffff_ffff, 32'h8000_0000);
        queue_request(32'h8000_0000, 32'h7fff_ffff);
        queue_request(32'h5555_5555, 32'haaaa_aaaa);
        drain_all();

        set_idling(0, 0);
        queue_random(PHASE_ITEMS);
        drain_all();
        set_idling(72, 0);
        queue_random(PHASE_ITEMS);
        drain_all();
        set_idling(0, 72);
        queue_random(PHASE_ITEMS);
        drain_all();
        set_idling(25, 25);
        queue_random(PHASE_ITEMS);
        drain_all();

        // sink held off long enough that a finished result backs up the request side
        set_idling(0, 0);
        hold_trigger = 1'b1;
        @(negedge clk);
        hold_trigger = 1'b0;
        queue_random(4);
        drain_all();

        set_idling(0, 0);
        queue_random(PHASE_ITEMS);
        drain_all();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_choices.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_choices.size()));

        $display("divider search: %0d searches under four handshake mixes and one long sink stall",
                 searches_accepted);
        $display("%0d results checked, %0d of them with no fitting pair, %0d mismatches",
                 results_checked, unfit_results, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
